/* src/lkv_pkg.sv */
// Shared definitions for the LRU key-value cache.
// Holds the operation codes, the store command struct and the capacity register width.
// No dependencies.
`default_nettype none

package lkv_pkg;

    typedef logic [1:0] t_op;

    localparam t_op OP_GET = 2'd0;
    localparam t_op OP_PUT = 2'd1;
    localparam t_op OP_DEL = 2'd2;

    localparam int CFG_W         = 5;
    localparam int OCC_W         = 5;
    localparam logic [CFG_W-1:0] CAPACITY_RESET = 5'd16;

    // Commands from the request decode to the entry store; at most one of
    // touch, remove and insert is set in a cycle.
    typedef struct packed {
        logic touch;       // make the hit entry most recent
        logic write_data;  // overwrite the hit entry's value
        logic remove;      // drop the hit entry
        logic insert;      // place a new key as most recent
        logic evict;       // drop the oldest entry before the insert
    } t_store_cmd;

endpackage

`default_nettype wire

/* src/lkv_store.sv */
// Entry store of the LRU key-value cache: valid bits, keys, values, recency ranks.
// Does the parallel key compare and applies one command per cycle.
// Depends on lkv_pkg.
`default_nettype none

module lkv_store
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [KEY_BITS-1:0]               i_key,
    input  wire logic [VALUE_BITS-1:0]             i_value,
    input  wire t_store_cmd                        i_cmd,
    output logic                                   o_found,
    output logic [VALUE_BITS-1:0]                  o_hit_data,
    output logic [$clog2(ENTRIES+1)-1:0]           o_count,
    output logic [$clog2(ENTRIES+1)-1:0]           o_count_next
);

    localparam int RANK_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES+1);

    logic [ENTRIES-1:0]    r_valid;
    logic [ENTRIES-1:0]    n_valid;
    logic [KEY_BITS-1:0]   r_key  [ENTRIES];
    logic [VALUE_BITS-1:0] r_data [ENTRIES];
    logic [RANK_W-1:0]     r_rank [ENTRIES];
    logic [RANK_W-1:0]     n_rank [ENTRIES];
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;

    logic [ENTRIES-1:0]    hit;
    logic [RANK_W-1:0]     hit_rank;
    logic [RANK_W-1:0]     oldest_rank;
    logic [ENTRIES-1:0]    evict_mask;
    logic [ENTRIES-1:0]    kept;
    logic [ENTRIES-1:0]    free;
    logic [ENTRIES-1:0]    slot;
    logic [ENTRIES-1:0]    wr_key;
    logic [ENTRIES-1:0]    wr_data;

    always_comb begin
        o_hit_data = '0;
        hit_rank   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit[i]     = r_valid[i] && (r_key[i] == i_key);
            o_hit_data = o_hit_data | ({VALUE_BITS{hit[i]}} & r_data[i]);
            hit_rank   = hit_rank | ({RANK_W{hit[i]}} & r_rank[i]);
        end
    end

    assign o_found = |hit;
    assign o_count = r_count;

    // Ranks of valid entries always run 0 .. count-1, so the oldest has rank count-1.
    assign oldest_rank = RANK_W'(r_count - CNT_W'(1));

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            evict_mask[i] = i_cmd.evict && r_valid[i] && (r_rank[i] == oldest_rank);
        end
    end

    assign kept = r_valid & ~evict_mask;
    assign free = ~kept;
    // isolate the lowest free slot
    assign slot = free & (~free + ENTRIES'(1));

    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        wr_key  = '0;
        wr_data = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
        end
        if (i_cmd.touch) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (hit[i]) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
            end
            if (i_cmd.write_data) begin
                wr_data = hit;
            end
        end else if (i_cmd.remove) begin
            n_valid = r_valid & ~hit;
            n_count = r_count - CNT_W'(1);
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_valid[i] && !hit[i] && (r_rank[i] > hit_rank)) begin
                    n_rank[i] = r_rank[i] - RANK_W'(1);
                end
            end
        end else if (i_cmd.insert) begin
            n_valid = kept | slot;
            wr_key  = slot;
            wr_data = slot;
            if (!i_cmd.evict) begin
                n_count = r_count + CNT_W'(1);
            end
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot[i]) begin
                    n_rank[i] = '0;
                end else if (kept[i]) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
            end
        end
    end

    assign o_count_next = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            r_rank[i] <= n_rank[i];
            if (wr_key[i]) begin
                r_key[i] <= i_key;
            end
            if (wr_data[i]) begin
                r_data[i] <= i_value;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("entry count differs from number of valid entries");

    a_hit_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hit))
        else $error("key present in more than one entry");

    a_insert_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> $onehot(slot))
        else $error("insert without a free slot");

    a_evict_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.evict |-> $onehot(evict_mask))
        else $error("eviction did not find exactly one oldest entry");

    a_insert_recent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |=> (r_count != '0))
        else $error("store empty after an insert");
`endif

endmodule

`default_nettype wire

/* src/lru_key_value_cache.sv */
// Top level of the LRU key-value cache: request register, decode, result register.
// Instantiates lkv_store; depends on lkv_pkg.
//
// Usage:
//   Request channel: drive i_op, i_lookup_key and i_write_value with i_start high;
//   the request is taken at any rising edge where o_busy is low. o_busy stays low,
//   so one request can be issued in every cycle.
//   Result channel: o_done is high for exactly one cycle with o_found,
//   o_read_value, o_evicted and o_occupancy. There is no back-pressure; the
//   receiver must take the result in that cycle.
//   Path: the request register takes the request at the accepting edge; lookup and
//   update then run combinationally into the result register.
//   Throughput: 1 request per cycle; the next request sees the store as left by
//   the previous one, since the store registers take the full compare and recency update first.
//   Configuration: i_cfg_data (capacity) is taken when i_cfg_valid is high;
//   o_cfg_ready is always high. Write it only while no request is in flight.
//   Reset: synchronous, active low; empties the store, clears pending requests
//   and results and sets the capacity to 16. No clearing pass is needed.
`default_nettype none

module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire logic [1:0]            i_op,
    input  wire logic [KEY_BITS-1:0]   i_lookup_key,
    input  wire logic [VALUE_BITS-1:0] i_write_value,
    output logic                       o_done,
    output logic                       o_found,
    output logic [VALUE_BITS-1:0]      o_read_value,
    output logic                       o_evicted,
    output logic [OCC_W-1:0]           o_occupancy,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_W-1:0]      i_cfg_data
);

    localparam int CNT_W = $clog2(ENTRIES+1);
    localparam int CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

    logic                  r_req_valid;
    t_op                   r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [CFG_W-1:0]      r_capacity;

    logic                  r_done;
    logic                  r_found;
    logic [VALUE_BITS-1:0] r_read_value;
    logic                  r_evicted;
    logic [OCC_W-1:0]      r_occupancy;

    t_store_cmd            cmd;
    logic                  found;
    logic [VALUE_BITS-1:0] hit_data;
    logic [CNT_W-1:0]      count;
    logic [CNT_W-1:0]      count_next;
    logic [CMP_W-1:0]      cap_ext;
    logic [CMP_W-1:0]      eff_cap;
    logic                  full;
    logic                  n_found;
    logic [VALUE_BITS-1:0] n_read_value;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else begin
            r_req_valid <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op    <= i_op;
            r_key   <= i_lookup_key;
            r_value <= i_write_value;
        end
    end

    lkv_store #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key        (r_key),
        .i_value      (r_value),
        .i_cmd        (cmd),
        .o_found      (found),
        .o_hit_data   (hit_data),
        .o_count      (count),
        .o_count_next (count_next)
    );

    // capacity zero acts as one, anything above the store size as the store size
    assign cap_ext = CMP_W'(r_capacity);
    always_comb begin
        if (cap_ext == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
    end
    assign full = CMP_W'(count) >= eff_cap;

    always_comb begin
        cmd          = '0;
        n_found      = 1'b0;
        n_read_value = '0;
        if (r_req_valid) begin
            unique case (r_op)
                OP_GET: begin
                    n_found      = found;
                    cmd.touch    = found;
                    n_read_value = found ? hit_data : '0;
                end
                OP_PUT: begin
                    n_found = found;
                    if (found) begin
                        cmd.touch      = 1'b1;
                        cmd.write_data = 1'b1;
                    end else begin
                        cmd.insert = 1'b1;
                        cmd.evict  = full;
                    end
                end
                OP_DEL: begin
                    n_found    = found;
                    cmd.remove = found;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_req_valid) begin
            r_found      <= n_found;
            r_read_value <= n_read_value;
            r_evicted    <= cmd.evict;
            r_occupancy  <= OCC_W'(count_next);
        end
    end

    assign o_done       = r_done;
    assign o_found      = r_found;
    assign o_read_value = r_read_value;
    assign o_evicted    = r_evicted;
    assign o_occupancy  = r_occupancy;

`ifndef SYNTHESIS
    a_result_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req_valid |=> r_done)
        else $error("request produced no result");

    a_evict_only_on_put_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.evict |-> (cmd.insert && !found && full))
        else $error("eviction outside a put of a new key");

    a_single_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.touch, cmd.remove, cmd.insert}))
        else $error("more than one store command in a cycle");

    a_occupancy_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(count) <= CMP_W'(ENTRIES))
        else $error("occupancy above store size");
`endif

endmodule

`default_nettype wire

/* test/lru_key_value_cache_tb.sv */
// Self-checking testbench for lru_key_value_cache: directed and random requests, checked
// against an in-bench LRU store predictor. Depends on lkv_pkg and the lru_key_value_cache RTL.
`timescale 1ns / 100ps

module lru_key_value_cache_tb;
    import lkv_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int KEY_BITS    = 64;
    localparam int VALUE_BITS  = 64;
    localparam int POOL_KEYS   = 24;
    localparam int STALL_LIMIT = 2000;

    // Unused operation code: the cache must leave the store alone.
    localparam t_op OP_NONE = 2'd3;

    localparam logic [KEY_BITS-1:0] KEY_ZERO = '0;
    localparam logic [KEY_BITS-1:0] KEY_ONES = '1;

    typedef struct packed {
        logic                  found;
        logic [VALUE_BITS-1:0] read_value;
        logic                  evicted;
        logic [OCC_W-1:0]      occupancy;
    } t_cache_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    logic [1:0]            i_op;
    logic [KEY_BITS-1:0]   i_lookup_key;
    logic [VALUE_BITS-1:0] i_write_value;
    logic                  o_done;
    logic                  o_found;
    logic [VALUE_BITS-1:0] o_read_value;
    logic                  o_evicted;
    logic [OCC_W-1:0]      o_occupancy;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_W-1:0]      i_cfg_data;

    // Predicted store contents; rank 0 is the most recent entry.
    logic                  store_valid [ENTRIES];
    logic [KEY_BITS-1:0]   store_key [ENTRIES];
    logic [VALUE_BITS-1:0] store_data [ENTRIES];
    int                    store_rank [ENTRIES];
    int                    store_count;
    logic [CFG_W-1:0]      store_capacity;

    t_cache_result         pending_results[$];
    logic [KEY_BITS-1:0]   key_pool [POOL_KEYS];

    int error_count     = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int hit_count       = 0;
    int evict_count     = 0;
    int capacity_writes = 0;
    int idle_cycles     = 0;
    int sender_idle_pct = 0;

    lru_key_value_cache #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_op          (i_op),
        .i_lookup_key  (i_lookup_key),
        .i_write_value (i_write_value),
        .o_done        (o_done),
        .o_found       (o_found),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_occupancy   (o_occupancy),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic void reset_store();
        for (int i = 0; i < ENTRIES; i++) begin
            store_valid[i] = 1'b0;
            store_rank[i]  = 0;
        end
        store_count    = 0;
        store_capacity = CAPACITY_RESET;
    endfunction

    function automatic void touch_entry(int slot);
        int r;
        r = store_rank[slot];
        for (int i = 0; i < ENTRIES; i++) begin
            if (store_valid[i] && store_rank[i] < r) store_rank[i]++;
        end
        store_rank[slot] = 0;
    endfunction

    // Drop an entry and close the gap it leaves in the recency order.
    function automatic void drop_entry(int slot);
        int r;
        r = store_rank[slot];
        store_valid[slot] = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (store_valid[i] && store_rank[i] > r) store_rank[i]--;
        end
        if (store_count > 0) store_count--;
    endfunction

    function automatic t_cache_result apply_cache_request(t_op op, logic [KEY_BITS-1:0] key,
                                                          logic [VALUE_BITS-1:0] value);
        t_cache_result res;
        int            slot;
        int            limit;
        int            oldest;
        int            free_slot;
        res  = '0;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && store_valid[i] && store_key[i] == key) slot = i;
        end
        case (op)
            OP_GET: begin
                if (slot >= 0) begin
                    res.found      = 1'b1;
                    res.read_value = store_data[slot];
                    touch_entry(slot);
                end
            end
            OP_PUT: begin
                if (slot >= 0) begin
                    res.found        = 1'b1;
                    store_data[slot] = value;
                    touch_entry(slot);
                end else begin
                    // Zero capacity acts as one, anything above the store size as full size.
                    limit = (store_capacity == 0) ? 1 :
                            (store_capacity > ENTRIES) ? ENTRIES : int'(store_capacity);
                    if (store_count >= limit) begin
                        oldest = -1;
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (store_valid[i] &&
                                (oldest < 0 || store_rank[i] > store_rank[oldest])) oldest = i;
                        end
                        if (oldest >= 0) drop_entry(oldest);
                        res.evicted = 1'b1;
                    end
                    free_slot = -1;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (free_slot < 0 && !store_valid[i]) free_slot = i;
                    end
                    if (free_slot >= 0) begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (store_valid[i]) store_rank[i]++;
                        end
                        store_valid[free_slot] = 1'b1;
                        store_key[free_slot]   = key;
                        store_data[free_slot]  = value;
                        store_rank[free_slot]  = 0;
                        store_count++;
                    end
                end
            end
            OP_DEL: begin
                if (slot >= 0) begin
                    res.found = 1'b1;
                    drop_entry(slot);
                end
            end
            default: ;
        endcase
        res.occupancy = store_count[OCC_W-1:0];
        return res;
    endfunction

    function automatic void report_mismatch(string msg);
        $display("ERROR %0t: %s", $time, msg);
        error_count++;
    endfunction

    task automatic send_request(t_op op, logic [KEY_BITS-1:0] key,
                                logic [VALUE_BITS-1:0] value);
        t_cache_result expected;
        // Idle the request channel with noise on the payload.
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            i_start       <= 1'b0;
            i_op          <= 2'($urandom);
            i_lookup_key  <= {$urandom, $urandom};
            i_write_value <= {$urandom, $urandom};
            @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_op          <= op;
        i_lookup_key  <= key;
        i_write_value <= value;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        expected = apply_cache_request(op, key, value);
        pending_results.push_back(expected);
        requests_sent++;
        if (expected.found) hit_count++;
        if (expected.evicted) evict_count++;
    endtask

    task automatic settle_cache();
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CFG_W-1:0] value);
        settle_cache();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid    <= 1'b0;
        store_capacity = value;
        capacity_writes++;
    endtask

    task automatic test_basic_operations();
        sender_idle_pct = 0;
        send_request(OP_GET, KEY_ZERO, '1);
        send_request(OP_DEL, KEY_ZERO, '1);
        send_request(OP_PUT, KEY_ZERO, '0);
        send_request(OP_PUT, KEY_ONES, '1);
        send_request(OP_PUT, 64'h5a5a_0f0f_a5a5_f0f0, 64'h0123_4567_89ab_cdef);
        send_request(OP_GET, KEY_ZERO, '1);
        send_request(OP_GET, KEY_ONES, '0);
        send_request(OP_PUT, KEY_ONES, 64'hfeed_0000_0000_beef);
        send_request(OP_NONE, KEY_ONES, '1);
        send_request(OP_DEL, 64'h5a5a_0f0f_a5a5_f0f0, '1);
        send_request(OP_GET, 64'h5a5a_0f0f_a5a5_f0f0, '0);
    endtask

    task automatic test_capacity_limits();
        // Two entries held; the all-ones key is most recent.
        write_capacity(5'd2);
        send_request(OP_PUT, 64'h1, 64'h1111);
        send_request(OP_GET, KEY_ZERO, '0);
        send_request(OP_GET, KEY_ONES, '0);
        send_request(OP_PUT, 64'h2, 64'h2222);
        // Zero capacity below occupancy: each new key evicts exactly one entry.
        write_capacity(5'd0);
        send_request(OP_PUT, 64'h3, 64'h3333);
        send_request(OP_PUT, 64'h4, 64'h4444);
        write_capacity(5'd31);
        send_request(OP_PUT, 64'h5, 64'h5555);
        send_request(OP_PUT, 64'h6, 64'h6666);
        send_request(OP_DEL, 64'h5, '0);
        send_request(OP_GET, 64'h6, '0);
    endtask

    task automatic test_random_traffic(int idle_pct, int n_requests);
        int                  pick;
        int                  pool_size;
        t_op                 op;
        logic [KEY_BITS-1:0] key;
        pool_size = POOL_KEYS;
        for (int i = 0; i < POOL_KEYS; i++) key_pool[i] = {$urandom, $urandom};
        for (int i = 0; i < n_requests; i++) begin
            if (i % 45 == 0) begin
                sender_idle_pct = 0;
                case ($urandom_range(5))
                    0:       write_capacity(5'd0);
                    1:       write_capacity(5'd1);
                    2:       write_capacity(5'd16);
                    3:       write_capacity(5'd31);
                    default: write_capacity(CFG_W'($urandom_range(31)));
                endcase
                pool_size       = $urandom_range(4, POOL_KEYS);
                sender_idle_pct = idle_pct;
            end
            pick = $urandom_range(99);
            op   = (pick < 40) ? OP_PUT : (pick < 80) ? OP_GET : (pick < 95) ? OP_DEL : OP_NONE;
            // Mostly reuse a small key set so hits, overwrites and evictions are common.
            key  = ($urandom_range(19) == 0) ? {$urandom, $urandom}
                                             : key_pool[$urandom_range(pool_size - 1)];
            send_request(op, key, {$urandom, $urandom});
        end
        settle_cache();
        sender_idle_pct = 0;
    endtask

    always @(posedge i_clk) begin
        t_cache_result expected;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                expected = pending_results.pop_front();
                results_checked++;
                if (o_found !== expected.found)
                    report_mismatch($sformatf("found: got %0b, expected %0b",
                                              o_found, expected.found));
                if (o_read_value !== expected.read_value)
                    report_mismatch($sformatf("read_value: got %0h, expected %0h",
                                              o_read_value, expected.read_value));
                if (o_evicted !== expected.evicted)
                    report_mismatch($sformatf("evicted: got %0b, expected %0b",
                                              o_evicted, expected.evicted));
                if (o_occupancy !== expected.occupancy)
                    report_mismatch($sformatf("occupancy: got %0d, expected %0d",
                                              o_occupancy, expected.occupancy));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no request or result for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_start       <= 1'b0;
        i_op          <= OP_GET;
        i_lookup_key  <= '0;
        i_write_value <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= CAPACITY_RESET;
        reset_store();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_operations();
        test_capacity_limits();
        test_random_traffic(0, 180);
        test_random_traffic(81, 180);
        test_random_traffic(33, 190);

        settle_cache();
        repeat (4) @(posedge i_clk);
        $display("Covered %0d requests, %0d results checked: %0d hits, %0d evictions",
                 requests_sent, results_checked, hit_count, evict_count);
        $display("Capacity written %0d times, %0d mismatches", capacity_writes, error_count);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
